@@ rtl/assert_macros.svh @@
// assertion macros included by the timer table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clock edge while reset is released
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// check on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

@@ rtl/ospt_pkg.sv @@
// types and constants of the timer table
package ospt_pkg;

  localparam int TIME_W  = 64;
  localparam int DELAY_W = 32;
  localparam int ID_W    = 31;
  localparam int CTX_W   = 2;
  localparam int MINP_W  = 20;

  localparam logic [MINP_W-1:0] MIN_PERIOD_RST = 20'd1000;

  typedef enum logic [1:0] {
    ACT_SET_ONCE     = 2'd0,
    ACT_SET_PERIODIC = 2'd1,
    ACT_CLEAR        = 2'd2,
    ACT_POLL         = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ID    = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DELAY = 2'd2,
    KIND_ACK   = 2'd3
  } kind_e;

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_SET        = 13'b0000000000010,
    S_CLR_RD     = 13'b0000000000100,
    S_CLR_CHK    = 13'b0000000001000,
    S_CLR_ACK    = 13'b0000000010000,
    S_POLL_RD    = 13'b0000000100000,
    S_POLL_EVAL  = 13'b0000001000000,
    S_POLL_FIRE  = 13'b0000010000000,
    S_POLL_RESCH = 13'b0000100000000,
    S_POLL_DIFF  = 13'b0001000000000,
    S_POLL_BEST  = 13'b0010000000000,
    S_POLL_WR    = 13'b0100000000000,
    S_POLL_DONE  = 13'b1000000000000
  } state_e;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [DELAY_W-1:0] period;
    logic [ID_W-1:0]    ident;
    logic [CTX_W-1:0]   owner;
    logic               active;
  } entry_t;

  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              carry;
  } alu_rsp_t;

endpackage

@@ rtl/ospt_ram.sv @@
// generic single write port ram with registered read
module ospt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ospt_alu.sv @@
// shared 64-bit add/subtract unit with saturating add
module ospt_alu (
  input  ospt_pkg::alu_req_t req_i,
  output ospt_pkg::alu_rsp_t rsp_o
);
  import ospt_pkg::*;

  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] b_eff;

  always_comb begin
    b_eff = req_i.sub ? ~req_i.b : req_i.b;
    sum   = {1'b0, req_i.a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, req_i.sub};
    rsp_o.carry = sum[TIME_W];
    // an add that overflows sticks at all ones; a subtract keeps the raw difference
    if (!req_i.sub && sum[TIME_W]) begin
      rsp_o.res = '1;
    end else begin
      rsp_o.res = sum[TIME_W-1:0];
    end
  end

endmodule

@@ rtl/one_shot_and_periodic_timer_table.sv @@
// timer table top level: sequencer, slot memory, shared adder and output register
//
// Table of up to MAX_TIMERS one-shot or periodic timers kept in insertion order in a
// single-port-read slot memory, processed one item at a time through one 64-bit
// add/subtract unit. in_stall_o is high from the transfer of an item until its last
// result has been handed to the output register. A set writes the new slot at the
// end of the table. A clear reads slot by slot until the match and marks it inactive,
// then acknowledges, also when nothing matches. A poll walks every used slot: an
// inactive slot is skipped, a slot of another context is written back, a due one-shot
// of the polled context is reported, a pending slot of the polled context goes through
// the minimum compare, and a due periodic slot is reported, rescheduled and given a
// fresh distance compare; then the poll finds the end of the table, hands out the
// next-delay result and returns to idle. The steps come from the memory's registered
// read and from the adder, which serves every deadline sum, distance and minimum
// compare in turn. Output stalls hold the sequencer in the states that emit a result.
module one_shot_and_periodic_timer_table #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ospt_pkg::MINP_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [ospt_pkg::CTX_W-1:0]   context_req_i,
  input  logic [ospt_pkg::DELAY_W-1:0] delay_us_i,
  input  logic [ospt_pkg::ID_W-1:0]    timer_id_i,
  input  logic [ospt_pkg::TIME_W-1:0]  now_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic                         status_o,
  output logic [ospt_pkg::ID_W-1:0]    timer_id_res_o,
  output logic [ospt_pkg::TIME_W-1:0]  next_delay_o,
  output logic                         last_o
);
  import ospt_pkg::*;

  `include "assert_macros.svh"

  localparam int CntW = $clog2(MAX_TIMERS + 1);
  localparam int IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int EntW = $bits(entry_t);

  state_e state_q, state_d;

  logic [MINP_W-1:0]  min_period_q;
  action_e            act_q;
  logic [CTX_W-1:0]   ctx_q;
  logic [DELAY_W-1:0] delay_q;
  logic [ID_W-1:0]    id_q;
  logic [TIME_W-1:0]  now_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] wr_idx_q, wr_idx_d;
  logic [ID_W-1:0] next_id_q, next_id_d;

  entry_t            ent_q, ent_d;
  logic [TIME_W-1:0] diff_q, diff_d;
  logic [TIME_W-1:0] best_q, best_d;

  logic              out_valid_q;
  kind_e             kind_q;
  logic              status_q;
  logic [ID_W-1:0]   res_id_q;
  logic [TIME_W-1:0] res_delay_q;
  logic              last_q;

  logic              emit;
  kind_e             emit_kind;
  logic              emit_status;
  logic [ID_W-1:0]   emit_id;
  logic [TIME_W-1:0] emit_delay;
  logic              emit_last;

  logic              out_free;
  logic              in_xfer;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [EntW-1:0]   ram_rdata_raw;
  logic [DELAY_W-1:0] eff_delay;
  logic              sub_due;
  logic [ID_W-1:0]   id_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // slot memory
  ospt_ram #(
    .Width(EntW),
    .Depth(MAX_TIMERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q[IdxW-1:0]),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  ospt_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  // short periods are raised to the configured minimum
  always_comb begin
    eff_delay = delay_q;
    if (act_q == ACT_SET_PERIODIC && delay_q < {{(DELAY_W-MINP_W){1'b0}}, min_period_q}) begin
      eff_delay = {{(DELAY_W-MINP_W){1'b0}}, min_period_q};
    end
  end

  assign id_inc  = next_id_q + {{(ID_W-1){1'b0}}, 1'b1};
  // a subtract result of zero or a borrow means the deadline is reached
  assign sub_due = !alu_rsp.carry || (alu_rsp.res == '0);

  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = now_q;
    alu_req.b   = '0;
    unique case (state_q)
      S_SET: begin
        alu_req.b = {{(TIME_W-DELAY_W){1'b0}}, eff_delay};
      end
      S_POLL_EVAL: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ram_rdata.deadline;
        alu_req.b   = now_q;
      end
      S_POLL_RESCH: begin
        alu_req.b = {{(TIME_W-DELAY_W){1'b0}}, ent_q.period};
      end
      S_POLL_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ent_q.deadline;
        alu_req.b   = now_q;
      end
      S_POLL_BEST: begin
        alu_req.sub = 1'b1;
        alu_req.a   = diff_q;
        alu_req.b   = best_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    next_id_d = next_id_q;
    ent_d     = ent_q;
    diff_d    = diff_q;
    best_d    = best_q;

    ram_we    = 1'b0;
    ram_waddr = wr_idx_q[IdxW-1:0];
    ram_wdata = ent_q;

    emit        = 1'b0;
    emit_kind   = KIND_ACK;
    emit_status = 1'b0;
    emit_id     = '0;
    emit_delay  = '0;
    emit_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          rd_idx_d = '0;
          wr_idx_d = '0;
          best_d   = '1;
          priority if (action_i == ACT_CLEAR) begin
            state_d = S_CLR_RD;
          end else if (action_i == ACT_POLL) begin
            state_d = S_POLL_RD;
          end else begin
            state_d = S_SET;
          end
        end
      end

      S_SET: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_ID;
          state_d   = S_IDLE;
          if (cnt_q == CntW'(MAX_TIMERS)) begin
            emit_status = 1'b1;
          end else begin
            emit_id          = next_id_q;
            next_id_d        = (id_inc == '0) ? {{(ID_W-1){1'b0}}, 1'b1} : id_inc;
            ram_we           = 1'b1;
            ram_waddr        = cnt_q[IdxW-1:0];
            ram_wdata.deadline = alu_rsp.res;
            ram_wdata.period = (act_q == ACT_SET_PERIODIC) ? eff_delay : '0;
            ram_wdata.ident  = next_id_q;
            ram_wdata.owner  = ctx_q;
            ram_wdata.active = 1'b1;
            cnt_d            = cnt_q + CntW'(1);
          end
        end
      end

      S_CLR_RD: begin
        state_d = (rd_idx_q == cnt_q) ? S_CLR_ACK : S_CLR_CHK;
      end

      S_CLR_CHK: begin
        if (ram_rdata.owner == ctx_q && ram_rdata.ident == id_q) begin
          ram_we           = 1'b1;
          ram_waddr        = rd_idx_q[IdxW-1:0];
          ram_wdata        = ram_rdata;
          ram_wdata.active = 1'b0;
          state_d          = S_CLR_ACK;
        end else begin
          rd_idx_d = rd_idx_q + CntW'(1);
          state_d  = S_CLR_RD;
        end
      end

      S_CLR_ACK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_ACK;
          state_d   = S_IDLE;
        end
      end

      S_POLL_RD: begin
        state_d = (rd_idx_q == cnt_q) ? S_POLL_DONE : S_POLL_EVAL;
      end

      S_POLL_EVAL: begin
        ent_d  = ram_rdata;
        diff_d = sub_due ? '0 : alu_rsp.res;
        priority if (!ram_rdata.active) begin
          rd_idx_d = rd_idx_q + CntW'(1);
          state_d  = S_POLL_RD;
        end else if (ram_rdata.owner == ctx_q && sub_due) begin
          state_d = S_POLL_FIRE;
        end else if (ram_rdata.owner == ctx_q) begin
          state_d = S_POLL_BEST;
        end else begin
          state_d = S_POLL_WR;
        end
      end

      S_POLL_FIRE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_FIRED;
          emit_id   = ent_q.ident;
          emit_last = 1'b0;
          if (ent_q.period != '0) begin
            state_d = S_POLL_RESCH;
          end else begin
            rd_idx_d = rd_idx_q + CntW'(1);
            state_d  = S_POLL_RD;
          end
        end
      end

      S_POLL_RESCH: begin
        ent_d.deadline = alu_rsp.res;
        state_d        = S_POLL_DIFF;
      end

      S_POLL_DIFF: begin
        diff_d  = sub_due ? '0 : alu_rsp.res;
        state_d = S_POLL_BEST;
      end

      S_POLL_BEST: begin
        // borrow means the distance is below the best so far
        if (!alu_rsp.carry) begin
          best_d = diff_q;
        end
        state_d = S_POLL_WR;
      end

      S_POLL_WR: begin
        ram_we   = 1'b1;
        wr_idx_d = wr_idx_q + CntW'(1);
        rd_idx_d = rd_idx_q + CntW'(1);
        state_d  = S_POLL_RD;
      end

      S_POLL_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_DELAY;
          emit_delay = best_q;
          cnt_d      = wr_idx_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      min_period_q <= MIN_PERIOD_RST;
      cnt_q        <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      next_id_q    <= {{(ID_W-1){1'b0}}, 1'b1};
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      wr_idx_q  <= wr_idx_d;
      next_id_q <= next_id_d;
      if (cfg_we_i) begin
        min_period_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q   <= action_e'(action_i);
      ctx_q   <= context_req_i;
      delay_q <= delay_us_i;
      id_q    <= timer_id_i;
      now_q   <= now_i;
    end
    ent_q  <= ent_d;
    diff_q <= diff_d;
    best_q <= best_d;
    if (emit) begin
      kind_q      <= emit_kind;
      status_q    <= emit_status;
      res_id_q    <= emit_id;
      res_delay_q <= emit_delay;
      last_q      <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign status_o       = status_q;
  assign timer_id_res_o = res_id_q;
  assign next_delay_o   = res_delay_q;
  assign last_o         = last_q;

  `ASSERT_RST(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(MAX_TIMERS))
  `ASSERT_RST(a_compact_order, clk_i, rst_ni, wr_idx_q <= rd_idx_q)
  `ASSERT_RST(a_id_nonzero, clk_i, rst_ni, next_id_q != '0)
  `ASSERT_RST(a_busy_after_xfer, clk_i, rst_ni, in_xfer |=> in_stall_o)

endmodule
